// ===== hdl/nbcs_pkg.sv =====
// ----------------------------------------------------------------------------
// nbcs_pkg
// Types, constants and helper functions shared by the blink code sequencer.
// ----------------------------------------------------------------------------
package nbcs_pkg;

    localparam int TIMER_W   = 16;   // phase timer width, 10 to 32
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 4;
    localparam int NUM_W     = 16;
    localparam int DIGIT_W   = 4;
    localparam int NDIGITS   = 3;
    localparam int CLAMP_W   = 10;

    localparam logic [CLAMP_W-1:0] NUM_MAX = CLAMP_W'(999);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FLASH_ON    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_FLASH_OFF   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_ON     = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_DIGIT_PAUSE = CFG_IDX_W'(3);

    localparam logic [CFG_W-1:0] FLASH_ON_RST    = CFG_W'(160);
    localparam logic [CFG_W-1:0] FLASH_OFF_RST   = CFG_W'(160);
    localparam logic [CFG_W-1:0] ZERO_ON_RST     = CFG_W'(160 * 3);
    localparam logic [CFG_W-1:0] DIGIT_PAUSE_RST = CFG_W'(800);

    // request codes
    localparam logic FUNC_TICK  = 1'b0;
    localparam logic FUNC_START = 1'b1;

    typedef logic [DIGIT_W-1:0] t_digit;
    typedef t_digit [NDIGITS-1:0] t_digits;   // [0] hundreds, [1] tens, [2] units

    typedef struct packed {
        logic             func;
        logic [NUM_W-1:0] number;
    } t_in_req;

    typedef struct packed {
        logic lamp_on;
        logic busy_res;
        logic finished;
    } t_out_res;

    // registered request after digit split
    typedef struct packed {
        logic    func;
        t_digits digs;
    } t_item;

    // clamp to 999 and split into decimal digits by threshold compares
    function automatic t_digits split_digits(input logic [NUM_W-1:0] number);
        logic [CLAMP_W-1:0] n;
        logic [CLAMP_W-1:0] hund_sub;
        logic [6:0]         rem;
        logic [6:0]         tens_sub;
        t_digit             h;
        t_digit             t;
        t_digits            d;
        n = (number > NUM_W'(NUM_MAX)) ? NUM_MAX : number[CLAMP_W-1:0];
        h = '0;
        for (int k = 1; k <= 9; k++) begin
            if (n >= CLAMP_W'(k * 100)) begin
                h = DIGIT_W'(k);
            end
        end
        hund_sub = (CLAMP_W'(h) << 6) + (CLAMP_W'(h) << 5) + (CLAMP_W'(h) << 2);
        rem = 7'(n - hund_sub);
        t = '0;
        for (int k = 1; k <= 9; k++) begin
            if (rem >= 7'(k * 10)) begin
                t = DIGIT_W'(k);
            end
        end
        tens_sub = (7'(t) << 3) + (7'(t) << 1);
        d[0] = h;
        d[1] = t;
        d[2] = DIGIT_W'(rem - tens_sub);
        return d;
    endfunction

    // phase length: optional floor of one, saturate to the timer range
    function automatic logic [TIMER_W-1:0] load_time(input logic [CFG_W-1:0] ticks,
                                                     input logic at_least_one);
        localparam int WIDE_W = (CFG_W > TIMER_W) ? CFG_W : TIMER_W;
        localparam logic [WIDE_W-1:0] TMAX = WIDE_W'({TIMER_W{1'b1}});
        logic [WIDE_W-1:0] w;
        w = WIDE_W'(ticks);
        if (at_least_one && (ticks == '0)) begin
            w = WIDE_W'(1);
        end
        if (w > TMAX) begin
            w = TMAX;
        end
        return TIMER_W'(w);
    endfunction

endpackage

// ===== hdl/nbcs_in_stage.sv =====
// ----------------------------------------------------------------------------
// nbcs_in_stage
// Input register; splits the start number into digits on the way in.
// ----------------------------------------------------------------------------
module nbcs_in_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  nbcs_pkg::t_in_req i_in_req,
    output logic             o_item_valid,
    input  logic             i_item_take,
    output nbcs_pkg::t_item  o_item
);

    logic            r_valid;
    nbcs_pkg::t_item r_item;
    logic            accept;

    assign o_in_stall   = r_valid && !i_item_take;
    assign accept       = i_in_valid && !o_in_stall;
    assign o_item_valid = r_valid;
    assign o_item       = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_item_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item.func <= i_in_req.func;
            r_item.digs <= nbcs_pkg::split_digits(i_in_req.number);
        end
    end

endmodule

// ===== hdl/nbcs_seq.sv =====
// ----------------------------------------------------------------------------
// nbcs_seq
// Blink phase sequencer and configuration registers; one request per cycle while i_take is high.
// ----------------------------------------------------------------------------
module nbcs_seq (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    input  logic [nbcs_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [nbcs_pkg::CFG_W-1:0]         i_cfg_data,
    input  logic                               i_take,
    input  nbcs_pkg::t_item                    i_item,
    output nbcs_pkg::t_out_res                 o_res
);

    typedef enum logic [1:0] {K_IDLE, K_ON, K_OFF, K_PAUSE} t_kind;

    logic [nbcs_pkg::CFG_W-1:0]   r_flash_on, r_flash_off, r_zero_on, r_pause;
    logic [nbcs_pkg::TIMER_W-1:0] r_timer, n_timer;
    nbcs_pkg::t_digits            r_digs, n_digs;
    logic [1:0]                   r_ptr, n_ptr;
    logic [3:0]                   r_flashes, n_flashes;
    t_kind                        r_kind, n_kind;
    logic                         r_running, n_running;

    logic                         done;
    logic                         do_begin;
    nbcs_pkg::t_digits            bd_digs;
    nbcs_pkg::t_digit             bd_d;
    logic [3:0]                   fl_dec;

    always_comb begin
        n_timer   = r_timer;
        n_digs    = r_digs;
        n_ptr     = r_ptr;
        n_flashes = r_flashes;
        n_kind    = r_kind;
        n_running = r_running;
        done      = 1'b0;
        do_begin  = 1'b0;
        bd_digs   = r_digs;
        fl_dec    = (r_flashes != '0) ? r_flashes - 4'd1 : r_flashes;

        if (i_item.func == nbcs_pkg::FUNC_START) begin
            if (!r_running) begin
                n_digs    = i_item.digs;
                bd_digs   = i_item.digs;
                n_running = 1'b1;
                do_begin  = 1'b1;
                if (i_item.digs[0] != '0) begin
                    n_ptr = 2'd0;
                end else if (i_item.digs[1] != '0) begin
                    n_ptr = 2'd1;
                end else begin
                    n_ptr = 2'd2;
                end
            end
        end else if (r_running) begin
            if (r_timer > nbcs_pkg::TIMER_W'(1)) begin
                n_timer = r_timer - nbcs_pkg::TIMER_W'(1);
            end else begin
                case (r_kind)
                    K_ON: begin
                        n_kind  = K_OFF;
                        n_timer = nbcs_pkg::load_time(r_flash_off, 1'b1);
                    end
                    K_OFF: begin
                        n_flashes = fl_dec;
                        if (fl_dec != '0) begin
                            n_kind  = K_ON;
                            n_timer = nbcs_pkg::load_time(r_flash_on, 1'b1);
                        end else if (r_ptr < 2'd2) begin
                            if (r_pause == '0) begin
                                n_ptr    = r_ptr + 2'd1;
                                do_begin = 1'b1;
                            end else begin
                                n_kind  = K_PAUSE;
                                n_timer = nbcs_pkg::load_time(r_pause, 1'b0);
                            end
                        end else begin
                            n_running = 1'b0;
                            n_kind    = K_IDLE;
                            n_timer   = '0;
                            done      = 1'b1;
                        end
                    end
                    K_PAUSE: begin
                        n_ptr    = r_ptr + 2'd1;
                        do_begin = 1'b1;
                    end
                    default: begin
                        // idle phase while running: settle to idle
                        n_running = 1'b0;
                        n_timer   = '0;
                        done      = 1'b1;
                    end
                endcase
            end
        end

        case (n_ptr)
            2'd0:    bd_d = bd_digs[0];
            2'd1:    bd_d = bd_digs[1];
            2'd2:    bd_d = bd_digs[2];
            default: bd_d = '0;
        endcase

        if (do_begin) begin
            n_kind    = K_ON;
            n_flashes = (bd_d == '0) ? 4'd1 : bd_d;
            n_timer   = nbcs_pkg::load_time((bd_d == '0) ? r_zero_on : r_flash_on, 1'b1);
        end
    end

    assign o_res.lamp_on  = n_running && (n_kind == K_ON);
    assign o_res.busy_res = n_running;
    assign o_res.finished = done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timer   <= '0;
            r_digs    <= '0;
            r_ptr     <= '0;
            r_flashes <= '0;
            r_kind    <= K_IDLE;
            r_running <= 1'b0;
        end else if (i_take) begin
            r_timer   <= n_timer;
            r_digs    <= n_digs;
            r_ptr     <= n_ptr;
            r_flashes <= n_flashes;
            r_kind    <= n_kind;
            r_running <= n_running;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flash_on  <= nbcs_pkg::FLASH_ON_RST;
            r_flash_off <= nbcs_pkg::FLASH_OFF_RST;
            r_zero_on   <= nbcs_pkg::ZERO_ON_RST;
            r_pause     <= nbcs_pkg::DIGIT_PAUSE_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                nbcs_pkg::CFG_FLASH_ON:    r_flash_on  <= i_cfg_data;
                nbcs_pkg::CFG_FLASH_OFF:   r_flash_off <= i_cfg_data;
                nbcs_pkg::CFG_ZERO_ON:     r_zero_on   <= i_cfg_data;
                nbcs_pkg::CFG_DIGIT_PAUSE: r_pause     <= i_cfg_data;
                default: ;
            endcase
        end
    end

endmodule

// ===== hdl/nbcs_out_buf.sv =====
// ----------------------------------------------------------------------------
// nbcs_out_buf
// Two-entry result buffer; full flag is registered so upstream never waits
// on the downstream stall combinationally.
// ----------------------------------------------------------------------------
module nbcs_out_buf (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  nbcs_pkg::t_out_res  i_res,
    output logic                o_full,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output nbcs_pkg::t_out_res  o_out_res
);

    nbcs_pkg::t_out_res r_buf [2];
    logic               r_wr, r_rd;
    logic [1:0]         r_cnt;
    logic               push, pop;

    assign o_full      = (r_cnt == 2'd2);
    assign o_out_valid = (r_cnt != 2'd0);
    assign o_out_res   = r_buf[r_rd];
    assign push        = i_push && !o_full;
    assign pop         = o_out_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wr <= !r_wr;
            end
            if (pop) begin
                r_rd <= !r_rd;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_buf[r_wr] <= i_res;
        end
    end

endmodule

// ===== hdl/number_blink_code_sequencer.sv =====
// ----------------------------------------------------------------------------
// number_blink_code_sequencer
// Shows a number (clamped to 999) on a status lamp as decimal blink codes.
// ----------------------------------------------------------------------------
// Takes one request per clock while the input is not stalled and returns
// one result per request. A start request splits the number into digits in
// the input register; once the result buffer has room, the phase sequencer
// updates its timer and phase and writes the lamp level into a two-entry
// result buffer, from which the result is offered. Input stall comes only
// from a full result buffer, i.e. from the result side holding off.
// Configuration registers may be written at any time (ready is tied high)
// but should only change while no sequence is running. No clearing pass
// after reset.
module number_blink_code_sequencer (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  nbcs_pkg::t_in_req              i_in_req,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output nbcs_pkg::t_out_res             o_out_res,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [nbcs_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [nbcs_pkg::CFG_W-1:0]     i_cfg_data
);

    logic               item_valid;
    logic               take;
    logic               buf_full;
    nbcs_pkg::t_item    item;
    nbcs_pkg::t_out_res res;

    assign o_cfg_ready = 1'b1;
    assign take        = item_valid && !buf_full;

    nbcs_in_stage u_in (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_in_req     (i_in_req),
        .o_item_valid (item_valid),
        .i_item_take  (take),
        .o_item       (item)
    );

    nbcs_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_take      (take),
        .i_item      (item),
        .o_res       (res)
    );

    nbcs_out_buf u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (take),
        .i_res       (res),
        .o_full      (buf_full),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_res   (o_out_res)
    );

endmodule

// ===== hdl/nbcs_chk.sv =====
// ----------------------------------------------------------------------------
// nbcs_chk
// Port-level checks for the blink code sequencer.
// ----------------------------------------------------------------------------
module nbcs_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input nbcs_pkg::t_out_res o_out_res
);

    // a lit lamp only while a sequence runs
    a_lamp_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_res.lamp_on |-> o_out_res.busy_res)
        else $error("lamp lit while not busy");

    // the finishing result leaves the block idle and dark
    a_finish_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_res.finished |-> !o_out_res.busy_res && !o_out_res.lamp_on)
        else $error("finished result still busy or lit");

    // reset empties the result buffer
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_res))
        else $error("stalled result changed");

endmodule

bind number_blink_code_sequencer nbcs_chk u_nbcs_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_res   (o_out_res)
);

// ===== tb/number_blink_code_sequencer_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// number_blink_code_sequencer_tb
// Self-checking bench for the blink code sequencer. A queue-fed driver offers
// tick and start requests with random gaps. Each accepted request runs
// through a cycle-free model of the digit/flash/pause sequencing. A monitor
// with random stalls checks lamp, busy and finished against that model.
// Timing registers are changed only between phases, once no blink sequence
// is running and all results have come back.
// ----------------------------------------------------------------------------
module number_blink_code_sequencer_tb;

    localparam int LIMIT_CYCLES = 2_000_000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_BATCH  = 8;

    typedef enum logic [1:0] {PH_IDLE, PH_ON, PH_OFF, PH_PAUSE} t_phase;

    typedef struct {
        nbcs_pkg::t_in_req req;
        int unsigned       gap;
    } t_pend_item;

    logic                           clk       = 1'b0;
    logic                           rst_n     = 1'b0;
    logic                           in_valid  = 1'b0;
    logic                           in_stall;
    nbcs_pkg::t_in_req              in_req    = '0;
    logic                           out_valid;
    logic                           rx_stall  = 1'b0;
    logic                           out_stall;
    nbcs_pkg::t_out_res             out_res;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [nbcs_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [nbcs_pkg::CFG_W-1:0]     cfg_data  = '0;

    // stimulus and expected results
    t_pend_item         pend_q[$];
    nbcs_pkg::t_out_res lamp_exp_q[$];
    nbcs_pkg::t_in_req  slot_req   = '0;
    bit                 slot_busy  = 1'b0;
    int unsigned        wait_left  = 0;
    int unsigned        rx_left    = 0;
    bit                 tx_calm    = 1'b0;
    bit                 rx_calm    = 1'b0;
    int unsigned        hold_ask   = 0;
    int unsigned        hold_seen  = 0;
    int unsigned        hold_left  = 0;
    int unsigned        cycle_cnt  = 0;
    int unsigned        mismatch_cnt = 0;

    // sequencer model state
    logic [nbcs_pkg::CFG_W-1:0]   blink_cfg [4];
    logic [nbcs_pkg::TIMER_W-1:0] ticks_left    = '0;
    logic [nbcs_pkg::DIGIT_W-1:0] shown [nbcs_pkg::NDIGITS];
    logic [1:0]                   digit_idx     = '0;
    logic [nbcs_pkg::DIGIT_W-1:0] flashes_left  = '0;
    t_phase                       kind          = PH_IDLE;
    bit                           blink_running = 1'b0;

    number_blink_code_sequencer dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_req    (in_req),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_res   (out_res),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    assign out_stall = rx_stall | (hold_left != 0);

    function automatic logic [nbcs_pkg::TIMER_W-1:0] phase_len(
            input logic [nbcs_pkg::CFG_W-1:0] ticks, input bit floor_one);
        longint unsigned v;
        longint unsigned vmax;
        v    = ticks;
        vmax = (longint'(1) << nbcs_pkg::TIMER_W) - 1;
        if (floor_one && v == 0) begin
            v = 1;
        end
        if (v > vmax) begin
            v = vmax;
        end
        return nbcs_pkg::TIMER_W'(v);
    endfunction

    task automatic open_digit();
        logic [nbcs_pkg::DIGIT_W-1:0] d;
        d = (digit_idx < nbcs_pkg::NDIGITS) ? shown[digit_idx] : '0;
        flashes_left = (d == 0) ? nbcs_pkg::DIGIT_W'(1) : d;
        kind = PH_ON;
        ticks_left = phase_len((d == 0) ? blink_cfg[nbcs_pkg::CFG_ZERO_ON]
                                        : blink_cfg[nbcs_pkg::CFG_FLASH_ON], 1'b1);
    endtask

    task automatic predict_blink(input nbcs_pkg::t_in_req r);
        logic [nbcs_pkg::NUM_W-1:0] n;
        nbcs_pkg::t_out_res         res;
        bit                         ended;
        ended = 1'b0;
        if (r.func == nbcs_pkg::FUNC_START) begin
            if (!blink_running) begin
                n = (r.number > nbcs_pkg::NUM_W'(nbcs_pkg::NUM_MAX))
                    ? nbcs_pkg::NUM_W'(nbcs_pkg::NUM_MAX) : r.number;
                shown[0] = nbcs_pkg::DIGIT_W'(n / 100);
                shown[1] = nbcs_pkg::DIGIT_W'((n / 10) % 10);
                shown[2] = nbcs_pkg::DIGIT_W'(n % 10);
                if (shown[0] != 0) begin
                    digit_idx = 2'd0;
                end else if (shown[1] != 0) begin
                    digit_idx = 2'd1;
                end else begin
                    digit_idx = 2'd2;
                end
                blink_running = 1'b1;
                open_digit();
            end
        end else if (blink_running) begin
            if (ticks_left > 1) begin
                ticks_left--;
            end else begin
                case (kind)
                    PH_ON: begin
                        kind = PH_OFF;
                        ticks_left = phase_len(blink_cfg[nbcs_pkg::CFG_FLASH_OFF], 1'b1);
                    end
                    PH_OFF: begin
                        if (flashes_left != 0) begin
                            flashes_left--;
                        end
                        if (flashes_left != 0) begin
                            kind = PH_ON;
                            ticks_left = phase_len(blink_cfg[nbcs_pkg::CFG_FLASH_ON], 1'b1);
                        end else if (digit_idx < nbcs_pkg::NDIGITS - 1) begin
                            if (blink_cfg[nbcs_pkg::CFG_DIGIT_PAUSE] == 0) begin
                                digit_idx++;
                                open_digit();
                            end else begin
                                kind = PH_PAUSE;
                                ticks_left = phase_len(
                                    blink_cfg[nbcs_pkg::CFG_DIGIT_PAUSE], 1'b0);
                            end
                        end else begin
                            blink_running = 1'b0;
                            kind = PH_IDLE;
                            ticks_left = '0;
                            ended = 1'b1;
                        end
                    end
                    PH_PAUSE: begin
                        digit_idx++;
                        open_digit();
                    end
                    default: begin
                        blink_running = 1'b0;
                        ticks_left = '0;
                        ended = 1'b1;
                    end
                endcase
            end
        end
        res.lamp_on  = blink_running && (kind == PH_ON);
        res.busy_res = blink_running;
        res.finished = ended;
        lamp_exp_q.push_back(res);
    endtask

    // driver: one request slot, loaded from the queue, held while stalled
    always @(posedge clk) begin : driver
        t_pend_item nxt;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall) begin
                predict_blink(in_req);
                slot_busy = 1'b0;
            end
            if (!slot_busy && pend_q.size() != 0) begin
                nxt       = pend_q.pop_front();
                slot_req  = nxt.req;
                wait_left = nxt.gap;
                slot_busy = 1'b1;
            end
            if (slot_busy && wait_left != 0) begin
                wait_left--;
                in_valid <= 1'b0;
            end else begin
                in_valid <= slot_busy;
            end
            in_req <= slot_req;
        end
    end

    always @(posedge clk) begin : monitor
        nbcs_pkg::t_out_res want;
        if (!rst_n) begin
            rx_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                if (lamp_exp_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %b",
                             $time, out_res);
                    mismatch_cnt++;
                end else begin
                    want = lamp_exp_q.pop_front();
                    if (out_res.lamp_on !== want.lamp_on) begin
                        $display("%0t: lamp_on expected %b actual %b",
                                 $time, want.lamp_on, out_res.lamp_on);
                        mismatch_cnt++;
                    end
                    if (out_res.busy_res !== want.busy_res) begin
                        $display("%0t: busy_res expected %b actual %b",
                                 $time, want.busy_res, out_res.busy_res);
                        mismatch_cnt++;
                    end
                    if (out_res.finished !== want.finished) begin
                        $display("%0t: finished expected %b actual %b",
                                 $time, want.finished, out_res.finished);
                        mismatch_cnt++;
                    end
                end
                rx_left = rx_calm ? 0 : $urandom_range(0, 15);
            end else if (rx_left != 0) begin
                rx_left--;
            end
            rx_stall <= (rx_left != 0);
        end
    end

    // long receiver hold-off so the result buffer fills and backs up the input
    always @(posedge clk) begin : holdoff
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (hold_seen != hold_ask) begin
            hold_seen <= hold_ask;
            hold_left <= HOLD_CYCLES;
        end
    end

    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
    end

    initial begin
        wait (cycle_cnt >= LIMIT_CYCLES);
        $display("%0t: timeout, %0d results outstanding", $time, lamp_exp_q.size());
        $display("Regression FAIL");
        $finish;
    end

    task automatic push_req(input logic f, input logic [nbcs_pkg::NUM_W-1:0] num);
        t_pend_item it;
        it.req.func   = f;
        it.req.number = num;
        it.gap        = tx_calm ? 0 : $urandom_range(0, 15);
        pend_q.push_back(it);
    endtask

    task automatic wait_quiet();
        do begin
            @(negedge clk);
        end while (pend_q.size() != 0 || slot_busy || lamp_exp_q.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    // tick until the model says the sequence is over
    task automatic drain_seq();
        wait_quiet();
        while (blink_running) begin
            repeat (DRAIN_BATCH) push_req(nbcs_pkg::FUNC_TICK, nbcs_pkg::NUM_W'($urandom));
            wait_quiet();
        end
    endtask

    task automatic write_reg(input logic [nbcs_pkg::CFG_IDX_W-1:0] idx,
                             input logic [nbcs_pkg::CFG_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx <= nbcs_pkg::CFG_DIGIT_PAUSE) begin
            blink_cfg[idx] = val;
        end
        @(negedge clk);
    endtask

    task automatic write_all(input logic [nbcs_pkg::CFG_W-1:0] on_t,
                             input logic [nbcs_pkg::CFG_W-1:0] off_t,
                             input logic [nbcs_pkg::CFG_W-1:0] zero_t,
                             input logic [nbcs_pkg::CFG_W-1:0] pause_t);
        write_reg(nbcs_pkg::CFG_FLASH_ON, on_t);
        write_reg(nbcs_pkg::CFG_FLASH_OFF, off_t);
        write_reg(nbcs_pkg::CFG_ZERO_ON, zero_t);
        write_reg(nbcs_pkg::CFG_DIGIT_PAUSE, pause_t);
    endtask

    function automatic logic [nbcs_pkg::NUM_W-1:0] pick_number();
        case ($urandom_range(0, 9))
            0:       return nbcs_pkg::NUM_W'($urandom_range(0, 9));
            1:       return nbcs_pkg::NUM_W'($urandom_range(10, 99));
            2:       return nbcs_pkg::NUM_W'(nbcs_pkg::NUM_MAX);
            3:       return nbcs_pkg::NUM_W'($urandom_range(1000, 65535));
            4:       return nbcs_pkg::NUM_W'($urandom);
            default: return nbcs_pkg::NUM_W'($urandom_range(0, 999));
        endcase
    endfunction

    function automatic logic [nbcs_pkg::CFG_W-1:0] pick_len();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return nbcs_pkg::CFG_W'(1);
            2:       return nbcs_pkg::CFG_W'($urandom_range(6, 24));
            default: return nbcs_pkg::CFG_W'($urandom_range(1, 5));
        endcase
    endfunction

    // start requests each followed by a run of ticks; a few stray starts
    task automatic random_phase(input int unsigned n_items, input bit squeeze);
        int unsigned made;
        int unsigned run_len;
        made = 0;
        write_all(pick_len(), pick_len(), pick_len(), pick_len());
        tx_calm = squeeze ? 1'b1 : ($urandom_range(0, 2) == 0);
        rx_calm = squeeze ? 1'b0 : ($urandom_range(0, 2) == 0);
        while (made < n_items) begin
            push_req(nbcs_pkg::FUNC_START, pick_number());
            made++;
            run_len = $urandom_range(0, 40);
            repeat (run_len) begin
                if ($urandom_range(0, 24) == 0) begin
                    push_req(nbcs_pkg::FUNC_START, pick_number());
                end else begin
                    push_req(nbcs_pkg::FUNC_TICK, nbcs_pkg::NUM_W'($urandom));
                end
                made++;
            end
        end
        if (squeeze) begin
            hold_ask++;
        end
        drain_seq();
    endtask

    initial begin
        logic [nbcs_pkg::NUM_W-1:0] edge_nums [10];
        edge_nums = '{nbcs_pkg::NUM_W'(nbcs_pkg::NUM_MAX), 16'd1000, 16'hFFFF, 16'd100,
                      16'd10, 16'd5, 16'd0, 16'd909, 16'd90, 16'd1};
        blink_cfg[nbcs_pkg::CFG_FLASH_ON]    = nbcs_pkg::FLASH_ON_RST;
        blink_cfg[nbcs_pkg::CFG_FLASH_OFF]   = nbcs_pkg::FLASH_OFF_RST;
        blink_cfg[nbcs_pkg::CFG_ZERO_ON]     = nbcs_pkg::ZERO_ON_RST;
        blink_cfg[nbcs_pkg::CFG_DIGIT_PAUSE] = nbcs_pkg::DIGIT_PAUSE_RST;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset timing: idle tick, a zero, and a start that lands while busy
        push_req(nbcs_pkg::FUNC_TICK, 16'hFFFF);
        push_req(nbcs_pkg::FUNC_START, 16'd0);
        push_req(nbcs_pkg::FUNC_START, 16'd7);
        drain_seq();

        // zero on/off times count as one tick, zero pause skips the pause
        write_all('0, '0, '0, '0);
        foreach (edge_nums[i]) begin
            push_req(nbcs_pkg::FUNC_START, edge_nums[i]);
            drain_seq();
        end
        write_all(nbcs_pkg::CFG_W'(2), nbcs_pkg::CFG_W'(1), nbcs_pkg::CFG_W'(3),
                  nbcs_pkg::CFG_W'(1));
        push_req(nbcs_pkg::FUNC_START, 16'd305);
        drain_seq();
        push_req(nbcs_pkg::FUNC_START, 16'd40);
        drain_seq();

        // out-of-range register index must not disturb the timing
        write_reg(nbcs_pkg::CFG_DIGIT_PAUSE + nbcs_pkg::CFG_IDX_W'($urandom_range(1, 12)),
                  nbcs_pkg::CFG_W'($urandom));
        push_req(nbcs_pkg::FUNC_START, 16'd12);
        drain_seq();

        for (int p = 0; p < 6; p++) begin
            random_phase(24, p == 2);
        end

        wait_quiet();
        repeat (8) @(negedge clk);
        if (mismatch_cnt == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
